// ===== hdl/lcube_pkg.sv =====
package lcube_pkg;

    // Cube edge length; rows and layers wrap at this count.
    localparam int CUBE_SIZE = 8;

    // The frame store always has 64 entries; a smaller cube uses the lower part.
    localparam int STORE_DEPTH = 64;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int FRAME_LEN   = CUBE_SIZE * CUBE_SIZE;

    // Scan position widths and the wrap limits.
    localparam int POS_W = 3;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(CUBE_SIZE - 1);
    localparam logic [STORE_AW:0] LAST_BYTE = (STORE_AW + 1)'(FRAME_LEN - 1);

    // Item kinds carried on the input tuser bit.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Register reset value and the all-off select pattern.
    localparam logic [7:0] START_MARKER_RESET = 8'hF2;
    localparam logic [7:0] SEL_ALL_OFF        = 8'hFF;

    // Store address of a scanned row: row * CUBE_SIZE + layer.
    function automatic logic [STORE_AW-1:0] scan_addr(input logic [POS_W-1:0] row,
                                                      input logic [POS_W-1:0] layer);
        logic [STORE_AW+POS_W:0] full;
        full = (STORE_AW + POS_W + 1)'(row) * (STORE_AW + POS_W + 1)'(CUBE_SIZE)
             + (STORE_AW + POS_W + 1)'(layer);
        return full[STORE_AW-1:0];
    endfunction

endpackage

// ===== hdl/led_cube_frame_loader_and_scanner.sv =====
// Frame loader and multiplex scanner for an LED cube. Every input transaction
// (a received byte or a scan tick, told apart by s_tuser) yields exactly one
// result transaction, one per clock cycle when both sides keep moving. Each
// result passes through the frame store's registered read and then through
// the output register. In idle, a byte equal to the start marker opens a
// frame and the next 64 bytes fill the store in order; the last one is
// flagged with m_tlast. A tick while idle drives one row of the current layer
// (m_tuser = 1) and steps the scan; ticks during upload give an all-off
// result. The store reads as zero after reset through per-entry valid bits,
// so no clearing pass is needed. The user must write the start marker through
// cfg_wr_en/cfg_wr_data while the block is idle; the block does not enforce it.
module led_cube_frame_loader_and_scanner
    import lcube_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: start marker register
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // Input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] item_kind
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] column_bits, [15:8] layer_select_n,
                                    // [23:16] row_select_n
    output logic        m_tuser,    // [0] drive_valid
    output logic        m_tlast     // frame_done
);

    // Control state
    logic [7:0]          start_marker_reg;
    logic                receiving_reg, receiving_next;
    logic [STORE_AW-1:0] byte_count_reg, byte_count_next;
    logic [POS_W-1:0]    scan_row_reg, scan_row_next;
    logic [POS_W-1:0]    scan_layer_reg, scan_layer_next;

    // Frame store and its per-entry valid bits
    logic [7:0]             store_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] store_ok_reg;

    // Read stage
    logic                s1_valid_reg;
    logic                s1_drive_reg;
    logic                s1_done_reg;
    logic [POS_W-1:0]    s1_row_reg;
    logic [POS_W-1:0]    s1_layer_reg;
    logic [7:0]          s1_rd_reg;
    logic                s1_rd_ok_reg;

    // Output register
    logic                out_valid_reg;
    logic [23:0]         out_data_reg;
    logic                out_drive_reg;
    logic                out_done_reg;

    logic                s_accept;
    logic                advance;
    logic                is_tick;
    logic                wr_en;
    logic                scan_now;
    logic                done_now;
    logic [STORE_AW-1:0] rd_addr;
    logic [7:0]          layer_n;
    logic [7:0]          row_n;

    // Handshake: the read stage moves on when the output register is free.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign is_tick  = (s_tuser == KIND_TICK);

    // Upload and scan state update for the accepted transaction.
    always_comb begin
        receiving_next  = receiving_reg;
        byte_count_next = byte_count_reg;
        scan_row_next   = scan_row_reg;
        scan_layer_next = scan_layer_reg;
        wr_en           = 1'b0;
        done_now        = 1'b0;
        scan_now        = 1'b0;
        if (s_accept) begin
            if (!is_tick) begin
                if (!receiving_reg) begin
                    if (s_tdata == start_marker_reg) begin
                        receiving_next  = 1'b1;
                        byte_count_next = '0;
                    end
                end else begin
                    wr_en = 1'b1;
                    if ({1'b0, byte_count_reg} >= LAST_BYTE) begin
                        receiving_next  = 1'b0;
                        byte_count_next = '0;
                        done_now        = 1'b1;
                    end else begin
                        byte_count_next = byte_count_reg + 1'b1;
                    end
                end
            end else if (!receiving_reg) begin
                scan_now = 1'b1;
                if (scan_row_reg >= LAST_POS) begin
                    scan_row_next   = '0;
                    scan_layer_next = (scan_layer_reg >= LAST_POS) ? '0
                                                                   : scan_layer_reg + 1'b1;
                end else begin
                    scan_row_next = scan_row_reg + 1'b1;
                end
            end
        end
    end

    assign rd_addr = scan_addr(scan_row_reg, scan_layer_reg);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg <= START_MARKER_RESET;
            receiving_reg    <= 1'b0;
            byte_count_reg   <= '0;
            scan_row_reg     <= '0;
            scan_layer_reg   <= '0;
            store_ok_reg     <= '0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                start_marker_reg <= cfg_wr_data;
            end
            receiving_reg  <= receiving_next;
            byte_count_reg <= byte_count_next;
            scan_row_reg   <= scan_row_next;
            scan_layer_reg <= scan_layer_next;
            if (wr_en) begin
                store_ok_reg[byte_count_reg] <= 1'b1;
            end
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Frame store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[byte_count_reg] <= s_tdata;
        end
        if (s_accept) begin
            s1_rd_reg <= store_mem[rd_addr];
        end
    end

    // Read stage payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_drive_reg <= scan_now;
            s1_done_reg  <= done_now;
            s1_row_reg   <= scan_row_reg;
            s1_layer_reg <= scan_layer_reg;
            s1_rd_ok_reg <= store_ok_reg[rd_addr];
        end
    end

    // Select encodings: one bit cleared per active layer and row.
    assign layer_n = s1_drive_reg ? ~(8'h01 << s1_layer_reg) : SEL_ALL_OFF;
    assign row_n   = s1_drive_reg ? ~(8'h80 >> s1_row_reg)   : SEL_ALL_OFF;

    // Output register
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg  <= {row_n, layer_n,
                              (s1_drive_reg && s1_rd_ok_reg) ? s1_rd_reg : 8'h00};
            out_drive_reg <= s1_drive_reg;
            out_done_reg  <= s1_done_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_drive_reg;
    assign m_tlast  = out_done_reg;

`ifndef SYNTHESIS
    // A driven row selects exactly one layer and one row.
    a_drive_one_cold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> ($onehot(~m_tdata[15:8]) && $onehot(~m_tdata[23:16])))
        else $error("driven row does not select exactly one layer and row");

    // A blanked result has all columns and selects off.
    a_blank_all_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == 24'hFFFF00))
        else $error("blanked result is not all off");

    // An upload ends only with the byte that is flagged as frame end.
    a_upload_end: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $fell(receiving_reg)) |-> (s1_valid_reg && s1_done_reg))
        else $error("upload ended without a frame end flag");

    // The scan position never moves during an upload.
    a_scan_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        receiving_reg |=> ($stable(scan_row_reg) && $stable(scan_layer_reg)))
        else $error("scan position moved during upload");
`endif

endmodule
